[src/fdl_pkg.sv]
// ----------------------------------------------------------------------------
// fdl_pkg
// Shared types and constants for the flanger delay line: register map,
// reset values, configuration bundle and the mid-scale sample value.
// ----------------------------------------------------------------------------
package fdl_pkg;

  // default sizing
  parameter int DELAY_DEPTH_DEF = 1024;
  parameter int LFO_BITS_DEF    = 12;

  // configuration register widths
  parameter int DIV_W   = 8;
  parameter int LIMIT_W = 12;
  parameter int MIND_W  = 10;
  parameter int SHIFT_W = 3;

  // sample widths
  parameter int ADC_W    = 10;
  parameter int SAMPLE_W = 8;
  parameter int DAC_W    = 12;

  // register bus
  parameter int PADDR_W = 4;
  parameter int PDATA_W = 32;

  // register indexes
  typedef enum logic [1:0] {
    REG_LFO_RATE_DIVIDER = 2'd0,
    REG_LFO_UPPER_LIMIT  = 2'd1,
    REG_MIN_DELAY        = 2'd2,
    REG_FEEDBACK_SHIFT   = 2'd3
  } reg_idx_t;

  // reset values
  parameter logic [DIV_W-1:0]   DIV_RST   = 8'd16;
  parameter logic [LIMIT_W-1:0] LIMIT_RST = 12'd4095;
  parameter logic [MIND_W-1:0]  MIND_RST  = 10'd16;
  parameter logic [SHIFT_W-1:0] SHIFT_RST = 3'd2;

  // value of a delay entry that was never written
  parameter logic [SAMPLE_W-1:0] SAMPLE_MID = 8'd128;

  // configuration bundle handed to the datapath
  typedef struct packed {
    logic [DIV_W-1:0]   rate_divider;
    logic [LIMIT_W-1:0] upper_limit;
    logic [MIND_W-1:0]  min_delay;
    logic [SHIFT_W-1:0] feedback_shift;
  } cfg_t;

endpackage

[src/fdl_ram.sv]
// ----------------------------------------------------------------------------
// fdl_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data (held while no read is issued).
// ----------------------------------------------------------------------------
module fdl_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, old data on a same-address write
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

[src/fdl_regs.sv]
// ----------------------------------------------------------------------------
// fdl_regs
// Configuration registers behind an APB-style port, zero wait states.
// ----------------------------------------------------------------------------
module fdl_regs (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fdl_pkg::PADDR_W-1:0]   paddr,
  input  logic [fdl_pkg::PDATA_W-1:0]   pwdata,
  output logic [fdl_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready,
  output fdl_pkg::cfg_t                 cfg
);

  fdl_pkg::cfg_t    cfg_r;
  fdl_pkg::cfg_t    cfg_nxt;
  fdl_pkg::reg_idx_t idx;
  logic             wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;
  assign idx    = fdl_pkg::reg_idx_t'(paddr[3:2]);

  // register write decode
  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_en) begin
      case (idx)
        fdl_pkg::REG_LFO_RATE_DIVIDER: cfg_nxt.rate_divider   = pwdata[fdl_pkg::DIV_W-1:0];
        fdl_pkg::REG_LFO_UPPER_LIMIT:  cfg_nxt.upper_limit    = pwdata[fdl_pkg::LIMIT_W-1:0];
        fdl_pkg::REG_MIN_DELAY:        cfg_nxt.min_delay      = pwdata[fdl_pkg::MIND_W-1:0];
        fdl_pkg::REG_FEEDBACK_SHIFT:   cfg_nxt.feedback_shift = pwdata[fdl_pkg::SHIFT_W-1:0];
        default:                       cfg_nxt = cfg_r;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.rate_divider   <= fdl_pkg::DIV_RST;
      cfg_r.upper_limit    <= fdl_pkg::LIMIT_RST;
      cfg_r.min_delay      <= fdl_pkg::MIND_RST;
      cfg_r.feedback_shift <= fdl_pkg::SHIFT_RST;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

  // read mux
  always_comb begin
    case (idx)
      fdl_pkg::REG_LFO_RATE_DIVIDER: prdata = fdl_pkg::PDATA_W'(cfg_r.rate_divider);
      fdl_pkg::REG_LFO_UPPER_LIMIT:  prdata = fdl_pkg::PDATA_W'(cfg_r.upper_limit);
      fdl_pkg::REG_MIN_DELAY:        prdata = fdl_pkg::PDATA_W'(cfg_r.min_delay);
      fdl_pkg::REG_FEEDBACK_SHIFT:   prdata = fdl_pkg::PDATA_W'(cfg_r.feedback_shift);
      default:                       prdata = '0;
    endcase
  end

  assign cfg = cfg_r;

endmodule

[src/fdl_lfo.sv]
// ----------------------------------------------------------------------------
// fdl_lfo
// Tick divider, triangle LFO and current delay. State moves once per
// accepted word; cur_delay is the delay that word uses.
// ----------------------------------------------------------------------------
module fdl_lfo #(
  parameter int LFO_BITS = fdl_pkg::LFO_BITS_DEF,
  parameter int ADDR_W   = 10
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 step,
  input  fdl_pkg::cfg_t        cfg,
  output logic [ADDR_W-1:0]    cur_delay
);

  localparam int CMP_W = (LFO_BITS > fdl_pkg::LIMIT_W) ? LFO_BITS : fdl_pkg::LIMIT_W;
  localparam int SUM_W = ((LFO_BITS - 3 > ADDR_W) ? LFO_BITS - 3 : ADDR_W) + 1;

  logic [fdl_pkg::DIV_W-1:0] tick_r, tick_nxt, tick_inc;
  logic [LFO_BITS-1:0]       level_r, level_nxt, level_new;
  logic                      falling_r, falling_nxt, falling_new;
  logic [ADDR_W-1:0]         delay_r, delay_nxt, delay_new;
  logic [SUM_W-1:0]          delay_sum;
  logic                      hit;

  // tick divider
  assign tick_inc = tick_r + 1'b1;
  assign hit      = (tick_inc == cfg.rate_divider);

  // triangle step
  always_comb begin
    if (!falling_r) begin
      level_new   = level_r + 1'b1;
      falling_new = (CMP_W'(level_new) >= CMP_W'(cfg.upper_limit));
    end else begin
      level_new   = level_r - 1'b1;
      falling_new = (level_new != '0);
    end
  end

  // delay from the new level, wrapped to the line length
  assign delay_sum = SUM_W'(level_new >> 3) + SUM_W'(cfg.min_delay);
  assign delay_new = delay_sum[ADDR_W-1:0];

  assign cur_delay = hit ? delay_new : delay_r;

  always_comb begin
    tick_nxt    = tick_r;
    level_nxt   = level_r;
    falling_nxt = falling_r;
    delay_nxt   = delay_r;
    if (step) begin
      tick_nxt = tick_inc;
      if (hit) begin
        tick_nxt    = '0;
        level_nxt   = level_new;
        falling_nxt = falling_new;
        delay_nxt   = delay_new;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      tick_r    <= '0;
      level_r   <= '0;
      falling_r <= 1'b0;
      delay_r   <= '0;
    end else begin
      tick_r    <= tick_nxt;
      level_r   <= level_nxt;
      falling_r <= falling_nxt;
      delay_r   <= delay_nxt;
    end
  end

endmodule

[src/fdl_mix.sv]
// ----------------------------------------------------------------------------
// fdl_mix
// Dry/delayed mix and feedback value. Picks the delayed sample from the
// forward path, the RAM, or mid-scale for an entry not yet written.
// ----------------------------------------------------------------------------
module fdl_mix (
  input  logic [fdl_pkg::SAMPLE_W-1:0] sample,
  input  logic [fdl_pkg::SAMPLE_W-1:0] ram_data,
  input  logic                         ram_ok,
  input  logic                         fwd,
  input  logic [fdl_pkg::SAMPLE_W-1:0] fwd_data,
  input  logic [fdl_pkg::SHIFT_W-1:0]  shift,
  output logic [fdl_pkg::SAMPLE_W-1:0] mix,
  output logic [fdl_pkg::SAMPLE_W-1:0] wr_data
);

  logic [fdl_pkg::SAMPLE_W-1:0] delayed;
  logic signed [fdl_pkg::SAMPLE_W:0] centered;
  logic signed [fdl_pkg::SAMPLE_W:0] fb;

  // delayed sample source
  always_comb begin
    if (fwd) begin
      delayed = fwd_data;
    end else if (ram_ok) begin
      delayed = ram_data;
    end else begin
      delayed = fdl_pkg::SAMPLE_MID;
    end
  end

  // average of the two halves
  assign mix = {1'b0, sample[fdl_pkg::SAMPLE_W-1:1]} + {1'b0, delayed[fdl_pkg::SAMPLE_W-1:1]};

  // centered mix, arithmetic shift, wrap into 8 bits
  assign centered = $signed({1'b0, mix}) - $signed({1'b0, fdl_pkg::SAMPLE_MID});
  assign fb       = centered >>> shift;
  assign wr_data  = sample + fb[fdl_pkg::SAMPLE_W-1:0];

endmodule

[src/flanger_delay_line_with_triangle_lfo.sv]
// ----------------------------------------------------------------------------
// flanger_delay_line_with_triangle_lfo
// Flanger: delay line with feedback, swept by a triangle LFO.
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_stall carries one 10-bit converter sample per word;
//   out_valid/out_stall returns one 12-bit DAC code per input word, in order.
//   Configuration goes through the APB-style port (psel/penable/...) while
//   the block is idle; registers sit at byte addresses 0, 4, 8 and 12.
// Timing:
//   An accepted word is registered in stage 1 and moves on into the output
//   register when stage 1 advances, which a stalled output can hold off.
//   Throughput is one word per clock while the output is not stalled: the
//   delay RAM's read port serves the word entering and its write port the
//   word leaving in the same cycle, with a bypass when both hit the same entry.
// Reset:
//   rst_n (synchronous) clears pointer, LFO, divider and pipeline. No RAM
//   sweep is needed: a fill flag marks entries below the write pointer as
//   written, and any other entry reads as mid-scale until the pointer wraps.
// Stall:
//   A stalled result holds in the output register; one more word can sit
//   in the read stage, after which in_stall is raised.
// ----------------------------------------------------------------------------
module flanger_delay_line_with_triangle_lfo #(
  parameter int DELAY_DEPTH = fdl_pkg::DELAY_DEPTH_DEF,
  parameter int LFO_BITS    = fdl_pkg::LFO_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  // sample input
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [fdl_pkg::ADC_W-1:0]     in_adc_sample,
  // result output
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic [fdl_pkg::DAC_W-1:0]     out_dac_code,
  // configuration
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [fdl_pkg::PADDR_W-1:0]   paddr,
  input  logic [fdl_pkg::PDATA_W-1:0]   pwdata,
  output logic [fdl_pkg::PDATA_W-1:0]   prdata,
  output logic                          pready
);

  localparam int ADDR_W = $clog2(DELAY_DEPTH);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DELAY_DEPTH - 1);

  fdl_pkg::cfg_t cfg;

  logic                          accept;
  logic                          s1_adv;
  logic [ADDR_W-1:0]             cur_delay;
  logic [ADDR_W-1:0]             rd_addr;
  logic                          rd_ok;
  logic                          fwd_hit;
  logic [fdl_pkg::SAMPLE_W-1:0]  ram_rdata;
  logic [fdl_pkg::SAMPLE_W-1:0]  mix;
  logic [fdl_pkg::SAMPLE_W-1:0]  wr_data;

  logic [ADDR_W-1:0]             wp_r, wp_nxt;
  logic                          filled_r, filled_nxt;
  logic                          s1_vld_r, s1_vld_nxt;
  logic [ADDR_W-1:0]             s1_wp_r;
  logic [fdl_pkg::SAMPLE_W-1:0]  s1_sample_r;
  logic                          s1_ok_r;
  logic                          s1_fwd_r;
  logic [fdl_pkg::SAMPLE_W-1:0]  s1_fwd_data_r;
  logic                          out_valid_r, out_valid_nxt;
  logic [fdl_pkg::DAC_W-1:0]     out_dac_r;

  // configuration registers
  fdl_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready),
    .cfg     (cfg)
  );

  // handshake
  assign s1_adv   = s1_vld_r && (!out_valid_r || !out_stall);
  assign in_stall = s1_vld_r && out_valid_r && out_stall;
  assign accept   = in_valid && !in_stall;

  // lfo and delay
  fdl_lfo #(
    .LFO_BITS (LFO_BITS),
    .ADDR_W   (ADDR_W)
  ) u_lfo (
    .clk       (clk),
    .rst_n     (rst_n),
    .step      (accept),
    .cfg       (cfg),
    .cur_delay (cur_delay)
  );

  // read address, fill check and bypass from the word leaving stage 1
  assign rd_addr = wp_r - cur_delay;
  assign rd_ok   = filled_r || (rd_addr < wp_r);
  assign fwd_hit = s1_adv && (rd_addr == s1_wp_r);

  // delay line
  fdl_ram #(
    .WIDTH (fdl_pkg::SAMPLE_W),
    .DEPTH (DELAY_DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (s1_adv),
    .waddr (s1_wp_r),
    .wdata (wr_data),
    .re    (accept),
    .raddr (rd_addr),
    .rdata (ram_rdata)
  );

  // mix and feedback
  fdl_mix u_mix (
    .sample   (s1_sample_r),
    .ram_data (ram_rdata),
    .ram_ok   (s1_ok_r),
    .fwd      (s1_fwd_r),
    .fwd_data (s1_fwd_data_r),
    .shift    (cfg.feedback_shift),
    .mix      (mix),
    .wr_data  (wr_data)
  );

  // control next state
  always_comb begin
    wp_nxt        = wp_r;
    filled_nxt    = filled_r;
    s1_vld_nxt    = s1_vld_r;
    out_valid_nxt = out_valid_r;
    if (accept) begin
      wp_nxt = wp_r + 1'b1;
      if (wp_r == LAST_ADDR) begin
        filled_nxt = 1'b1;
      end
      s1_vld_nxt = 1'b1;
    end else if (s1_adv) begin
      s1_vld_nxt = 1'b0;
    end
    if (s1_adv) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r        <= '0;
      filled_r    <= 1'b0;
      s1_vld_r    <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      wp_r        <= wp_nxt;
      filled_r    <= filled_nxt;
      s1_vld_r    <= s1_vld_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // stage 1 payload
  always_ff @(posedge clk) begin
    if (accept) begin
      s1_wp_r       <= wp_r;
      s1_sample_r   <= in_adc_sample[fdl_pkg::ADC_W-1:fdl_pkg::ADC_W-fdl_pkg::SAMPLE_W];
      s1_ok_r       <= rd_ok;
      s1_fwd_r      <= fwd_hit;
      s1_fwd_data_r <= wr_data;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (s1_adv) begin
      out_dac_r <= {mix, 4'b0000};
    end
  end

  assign out_valid    = out_valid_r;
  assign out_dac_code = out_dac_r;

endmodule

[tb/testbench.sv]
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the flanger delay line. A cycle-free model of the
// delay store, write pointer and triangle LFO predicts every DAC code. It is
// run through directed samples, register access, divider and ramp corner
// cases, a long output hold and randomized settings with random idling.
// ----------------------------------------------------------------------------
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int DEPTH  = fdl_pkg::DELAY_DEPTH_DEF;
  localparam int ADDR_W = $clog2(fdl_pkg::DELAY_DEPTH_DEF);

  // clock and reset
  logic clk = 1'b0;
  logic rst_n = 1'b0;

  // sample and result channels
  logic                        in_valid = 1'b0;
  logic                        in_stall;
  logic [fdl_pkg::ADC_W-1:0]   in_adc_sample = '0;
  logic                        out_valid;
  logic                        out_stall = 1'b0;
  logic [fdl_pkg::DAC_W-1:0]   out_dac_code;

  // register bus
  logic                        psel = 1'b0;
  logic                        penable = 1'b0;
  logic                        pwrite = 1'b0;
  logic [fdl_pkg::PADDR_W-1:0] paddr = '0;
  logic [fdl_pkg::PDATA_W-1:0] pwdata = '0;
  logic [fdl_pkg::PDATA_W-1:0] prdata;
  logic                        pready;

  // flanger model state
  logic [fdl_pkg::SAMPLE_W-1:0]     echo_line [0:DEPTH-1];
  logic [ADDR_W-1:0]                wr_ptr;
  logic [fdl_pkg::LFO_BITS_DEF-1:0] lfo_lvl;
  logic                             lfo_down;
  logic [7:0]                       tick_cnt;
  logic [ADDR_W-1:0]                sweep_delay;

  // model copy of the registers
  logic [fdl_pkg::DIV_W-1:0]    rate_div;
  logic [fdl_pkg::LIMIT_W-1:0]  ramp_limit;
  logic [fdl_pkg::MIND_W-1:0]   base_delay;
  logic [fdl_pkg::SHIFT_W-1:0]  fb_shift;

  // pending dac codes, oldest first
  logic [fdl_pkg::DAC_W-1:0]    dac_expect [$];
  logic [fdl_pkg::DAC_W-1:0]    dac_want;

  // stall and idle control
  bit                  idle_on = 1'b0;
  bit                  hold_req = 1'b0;
  bit                  hold_ack = 1'b0;
  int                  hold_len = 0;
  int                  stall_left = 0;

  // run statistics
  int                  mismatches = 0;
  int                  words_sent = 0;
  int                  codes_seen = 0;
  int                  reg_writes = 0;

  flanger_delay_line_with_triangle_lfo uut (
    .clk           (clk),
    .rst_n         (rst_n),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .in_adc_sample (in_adc_sample),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_dac_code  (out_dac_code),
    .psel          (psel),
    .penable       (penable),
    .pwrite        (pwrite),
    .paddr         (paddr),
    .pwdata        (pwdata),
    .prdata        (prdata),
    .pready        (pready)
  );

  always #10 clk = ~clk;

  // run limit
  initial begin
    #4000000;
    $display("simulation failed");
    $finish;
  end

  // one flanger step: lfo update, delayed read, mix and feedback write
  function automatic logic [fdl_pkg::DAC_W-1:0] flange_step(
      logic [fdl_pkg::ADC_W-1:0] adc);
    logic [fdl_pkg::SAMPLE_W-1:0] dry;
    logic [fdl_pkg::SAMPLE_W-1:0] wet;
    logic [fdl_pkg::SAMPLE_W-1:0] mix;
    logic [ADDR_W-1:0]            rd_addr;
    logic signed [8:0]            centered;
    logic signed [8:0]            fb;
    tick_cnt = tick_cnt + 8'd1;
    if (tick_cnt == rate_div) begin
      tick_cnt = '0;
      if (!lfo_down) begin
        lfo_lvl = lfo_lvl + 1'b1;
        lfo_down = (lfo_lvl >= ramp_limit);
      end else begin
        lfo_lvl = lfo_lvl - 1'b1;
        lfo_down = (lfo_lvl != '0);
      end
      sweep_delay = ADDR_W'(lfo_lvl >> 3) + base_delay;
    end
    dry = adc[fdl_pkg::ADC_W-1:2];
    rd_addr = wr_ptr - sweep_delay;
    wet = echo_line[rd_addr];
    mix = {1'b0, dry[7:1]} + {1'b0, wet[7:1]};
    centered = $signed({1'b0, mix}) - 9'sd128;
    fb = centered >>> fb_shift;
    echo_line[wr_ptr] = dry + fb[7:0];
    wr_ptr = wr_ptr + 1'b1;
    return {mix, 4'b0000};
  endfunction

  // send one sample word, predicting its code on acceptance
  task automatic send_sample(logic [fdl_pkg::ADC_W-1:0] adc);
    int gap;
    gap = idle_on ? $urandom_range(0, 11) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_adc_sample <= adc;
    do @(posedge clk); while (in_stall);
    dac_expect.push_back(flange_step(adc));
    words_sent++;
  endtask

  // stop offering words and wait for every pending code
  task automatic drain();
    in_valid <= 1'b0;
    while (dac_expect.size() != 0) @(posedge clk);
    repeat (4) @(posedge clk);
  endtask

  // bus write, setup then access
  task automatic reg_write(fdl_pkg::reg_idx_t idx, logic [fdl_pkg::PDATA_W-1:0] data);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    case (idx)
      fdl_pkg::REG_LFO_RATE_DIVIDER: rate_div = data[fdl_pkg::DIV_W-1:0];
      fdl_pkg::REG_LFO_UPPER_LIMIT:  ramp_limit = data[fdl_pkg::LIMIT_W-1:0];
      fdl_pkg::REG_MIN_DELAY:        base_delay = data[fdl_pkg::MIND_W-1:0];
      fdl_pkg::REG_FEEDBACK_SHIFT:   fb_shift = data[fdl_pkg::SHIFT_W-1:0];
      default: ;
    endcase
    reg_writes++;
  endtask

  // bus read, compared with the model's register copy
  task automatic reg_check(fdl_pkg::reg_idx_t idx);
    logic [fdl_pkg::PDATA_W-1:0] want;
    case (idx)
      fdl_pkg::REG_LFO_RATE_DIVIDER: want = fdl_pkg::PDATA_W'(rate_div);
      fdl_pkg::REG_LFO_UPPER_LIMIT:  want = fdl_pkg::PDATA_W'(ramp_limit);
      fdl_pkg::REG_MIN_DELAY:        want = fdl_pkg::PDATA_W'(base_delay);
      default:                       want = fdl_pkg::PDATA_W'(fb_shift);
    endcase
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= {idx, 2'b00};
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    if (prdata !== want) begin
      mismatches++;
      if (mismatches <= 10)
        $display("register %s read: expected %0d, got %0d", idx.name(), want, prdata);
    end
    psel <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
  endtask

  // set all four registers at once
  task automatic set_all(logic [fdl_pkg::PDATA_W-1:0] dv, logic [fdl_pkg::PDATA_W-1:0] lim,
                         logic [fdl_pkg::PDATA_W-1:0] md, logic [fdl_pkg::PDATA_W-1:0] sh);
    reg_write(fdl_pkg::REG_LFO_RATE_DIVIDER, dv);
    reg_write(fdl_pkg::REG_LFO_UPPER_LIMIT, lim);
    reg_write(fdl_pkg::REG_MIN_DELAY, md);
    reg_write(fdl_pkg::REG_FEEDBACK_SHIFT, sh);
  endtask

  // receiver: random stall per word, or a long hold on request
  always @(posedge clk) begin
    if (hold_req != hold_ack) begin
      hold_ack <= hold_req;
      stall_left <= hold_len;
      out_stall <= 1'b1;
    end else if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_stall <= 1'b1;
    end else if (out_valid && !out_stall && idle_on) begin
      stall_left <= $urandom_range(0, 11);
      out_stall <= 1'b0;
    end else begin
      out_stall <= 1'b0;
    end
  end

  // result checker
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (dac_expect.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("dac code %0d arrived with nothing pending", out_dac_code);
      end else begin
        dac_want = dac_expect.pop_front();
        codes_seen++;
        if (out_dac_code !== dac_want) begin
          mismatches++;
          if (mismatches <= 10)
            $display("dac code %0d: expected %0d, got %0d",
                     codes_seen, dac_want, out_dac_code);
        end
      end
    end
  end

  // reset values read back
  task automatic test_reset_values();
    reg_check(fdl_pkg::REG_LFO_RATE_DIVIDER);
    reg_check(fdl_pkg::REG_LFO_UPPER_LIMIT);
    reg_check(fdl_pkg::REG_MIN_DELAY);
    reg_check(fdl_pkg::REG_FEEDBACK_SHIFT);
  endtask

  // sample extremes and bit patterns, first words read at zero delay
  task automatic test_directed_samples();
    logic [fdl_pkg::ADC_W-1:0] pats [0:11];
    pats = '{10'd0, 10'd1023, 10'd3, 10'd1020, 10'h155, 10'h2AA,
             10'd512, 10'd511, 10'd4, 10'd1019, 10'd256, 10'd768};
    foreach (pats[i]) send_sample(pats[i]);
    idle_on <= 1'b1;
    for (int i = 0; i < 10; i++) send_sample(pats[i]);
    drain();
  endtask

  // full-width writes are masked
  task automatic test_register_access();
    set_all('1, '1, '1, '1);
    test_reset_values();
    for (int i = 0; i < 25; i++) send_sample(fdl_pkg::ADC_W'($urandom_range(0, 1023)));
    drain();
  endtask

  // divider zero steps only on wrap; a divider under the count also waits
  task automatic test_divider_wrap();
    set_all(0, 4095, 16, 2);
    for (int i = 0; i < 300; i++) send_sample(fdl_pkg::ADC_W'($urandom_range(0, 1023)));
    drain();
    // count is now well above five
    reg_write(fdl_pkg::REG_LFO_RATE_DIVIDER, 5);
    for (int i = 0; i < 230; i++) send_sample(fdl_pkg::ADC_W'($urandom_range(0, 1023)));
    drain();
  endtask

  // lowered limit under the level, then limit zero
  task automatic test_upper_limit();
    set_all(1, 4095, 40, 0);
    for (int i = 0; i < 40; i++) send_sample(fdl_pkg::ADC_W'($urandom_range(0, 1023)));
    drain();
    reg_write(fdl_pkg::REG_LFO_UPPER_LIMIT, 8);
    for (int i = 0; i < 80; i++) send_sample(fdl_pkg::ADC_W'($urandom_range(0, 1023)));
    drain();
    set_all(1, 0, 0, 7);
    for (int i = 0; i < 30; i++) send_sample(fdl_pkg::ADC_W'($urandom_range(0, 1023)));
    drain();
  endtask

  // long output hold while words keep coming
  task automatic test_backpressure();
    idle_on <= 1'b0;
    hold_len <= 80;
    hold_req <= ~hold_req;
    for (int i = 0; i < 40; i++) send_sample(fdl_pkg::ADC_W'($urandom_range(0, 1023)));
    drain();
    idle_on <= 1'b1;
  endtask

  // random settings per phase, random samples and idling
  task automatic test_random_sweep();
    logic [fdl_pkg::PDATA_W-1:0] dv;
    logic [fdl_pkg::PDATA_W-1:0] lim;
    logic [fdl_pkg::PDATA_W-1:0] md;
    logic [fdl_pkg::ADC_W-1:0]   adc;
    for (int ph = 0; ph < 6; ph++) begin
      case ($urandom_range(0, 3))
        0: dv = 1;
        1: dv = 255;
        2: dv = 0;
        default: dv = $urandom_range(1, 40);
      endcase
      case ($urandom_range(0, 3))
        0: lim = 0;
        1: lim = 4095;
        2: lim = 1;
        default: lim = $urandom_range(1, 200);
      endcase
      case ($urandom_range(0, 3))
        0: md = 0;
        1: md = 512;
        2: md = 1023;
        default: md = $urandom_range(0, 512);
      endcase
      // junk in the unused upper bits
      set_all(dv | ($urandom << fdl_pkg::DIV_W), lim | ($urandom << fdl_pkg::LIMIT_W),
              md | ($urandom << fdl_pkg::MIND_W), $urandom);
      idle_on <= ($urandom_range(0, 3) != 0);
      for (int i = 0; i < 100; i++) begin
        case ($urandom_range(0, 7))
          0: adc = '0;
          1: adc = '1;
          default: adc = fdl_pkg::ADC_W'($urandom_range(0, 1023));
        endcase
        send_sample(adc);
      end
      drain();
    end
  endtask

  // main sequence
  initial begin
    for (int i = 0; i < DEPTH; i++) echo_line[i] = fdl_pkg::SAMPLE_MID;
    wr_ptr = '0;
    lfo_lvl = '0;
    lfo_down = 1'b0;
    tick_cnt = '0;
    sweep_delay = '0;
    rate_div = fdl_pkg::DIV_RST;
    ramp_limit = fdl_pkg::LIMIT_RST;
    base_delay = fdl_pkg::MIND_RST;
    fb_shift = fdl_pkg::SHIFT_RST;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_values();
    test_directed_samples();
    test_register_access();
    test_divider_wrap();
    test_upper_limit();
    test_backpressure();
    test_random_sweep();

    drain();
    repeat (8) @(posedge clk);
    $display("%0d samples sent, %0d dac codes compared, %0d register writes",
             words_sent, codes_seen, reg_writes);
    $display("divider wrap, ramp turnarounds, zero and wrapped delays, long hold");
    if (mismatches == 0 && dac_expect.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

endmodule
